[rtl/pfr_pkg.sv]
// shared types, constants and the quarter-wave sine table of the planar frame rotator
`timescale 1ns / 1ps

package pfr_pkg;

    // default sizes of the top level
    localparam int ANGLE_BITS_DFLT = 16;
    localparam int DATA_BITS_DFLT  = 32;

    // fixed width of the heading field of an input item
    localparam int HEAD_W = 16;

    // item commands
    typedef enum logic [1:0] {
        CMD_SET_HEADING = 2'd0,
        CMD_ROT_FWD     = 2'd1,
        CMD_ROT_INV     = 2'd2,
        CMD_NONE        = 2'd3
    } pfr_cmd_t;

    // quarter-wave table geometry
    localparam int TAB_BITS = 10;
    localparam int TAB_SIZE = 1 << TAB_BITS;
    localparam int VAL_W    = 31;
    localparam int DIFF_W   = 24;
    localparam int TAB_W    = VAL_W + DIFF_W;

    // coefficient format: signed Q1.30 in 32 bits
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 30;
    localparam logic signed [COEF_W-1:0] ONE_Q30 = COEF_W'(64'd1 << COEF_FRAC);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30_U   = 64'd1 << COEF_FRAC;

    // (2n)(2n+1) for the odd taylor terms of sine
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // one table word: entry value and slope to the next entry
    typedef logic [TAB_W-1:0] rom_t [TAB_SIZE];

    typedef struct packed {
        logic [COEF_W-1:0] sin_v;
        logic [COEF_W-1:0] cos_v;
    } pfr_trig_t;

    // integer taylor series to the x^17 term, floored at every step
    function automatic rom_t build_rom();
        rom_t              rom;
        logic [63:0]       sine [TAB_SIZE+1];
        logic [63:0]       x;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic signed [63:0] acc;
        for (int k = 0; k <= TAB_SIZE; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) >> TAB_BITS;
            x2   = (x * x) >> COEF_FRAC;
            term = x;
            acc  = $signed(x);
            for (int n = 1; n <= 8; n++)
            begin
                term = (term * x2) >> COEF_FRAC;
                term = term / TAYLOR_DIV[n];
                if (n % 2 == 1)
                    acc = acc - $signed(term);
                else
                    acc = acc + $signed(term);
            end
            if (acc < 0)
                acc = '0;
            if (acc > $signed(ONE_Q30_U))
                acc = $signed(ONE_Q30_U);
            sine[k] = acc;
        end
        sine[TAB_SIZE] = ONE_Q30_U;
        for (int k = 0; k < TAB_SIZE; k++)
        begin
            rom[k] = {sine[k][VAL_W-1:0], DIFF_W'(sine[k+1] - sine[k])};
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

endpackage

[rtl/pfr_in_if.sv]
// input item channel: command, heading and vector
`timescale 1ns / 1ps

interface pfr_in_if
    import pfr_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DFLT
) ();

    logic                        valid;
    logic                        ready;
    logic [1:0]                  cmd;
    logic [HEAD_W-1:0]           heading;
    logic signed [DATA_BITS-1:0] vel_x;
    logic signed [DATA_BITS-1:0] vel_y;

    modport source (output valid, output cmd, output heading, output vel_x, output vel_y,
                    input ready);
    modport sink   (input valid, input cmd, input heading, input vel_x, input vel_y,
                    output ready);

endinterface

[rtl/pfr_out_if.sv]
// result item channel: rotated vector
`timescale 1ns / 1ps

interface pfr_out_if
    import pfr_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DFLT
) ();

    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] out_x;
    logic signed [DATA_BITS-1:0] out_y;

    modport source (output valid, output out_x, output out_y, input ready);
    modport sink   (input valid, input out_x, input out_y, output ready);

endinterface

[rtl/pfr_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module pfr_ram
#(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[rtl/pfr_sincos.sv]
// sine and cosine of the stored heading from a ram-held quarter-wave table
`timescale 1ns / 1ps

module pfr_sincos
    import pfr_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DFLT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic                  busy,
    output pfr_trig_t             trig
);

    localparam int SH     = ANGLE_BITS - 2 - TAB_BITS;
    localparam int SH_R   = (SH > 0) ? SH : 0;
    localparam int SH_L   = (SH < 0) ? -SH : 0;
    localparam int FRAC_W = (SH_R > 0) ? SH_R : 1;
    localparam int U_W    = ANGLE_BITS - 1;

    localparam logic [U_W-1:0]        QUARTER_U = U_W'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] QUARTER_A = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_SIN,
        ST_COS,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [TAB_BITS-1:0] addr;
        logic [FRAC_W-1:0]   frac;
        logic                full;
        logic                neg;
    } look_t;

    state_t                     state_reg;
    logic [TAB_BITS-1:0]        fill_reg;
    logic [ANGLE_BITS-1:0]      angle_reg;
    logic signed [COEF_W-1:0]   sin_reg;
    logic signed [COEF_W-1:0]   cos_reg;

    look_t                      look_s;
    look_t                      look_c;
    look_t                      info;
    logic [TAB_BITS-1:0]        raddr;
    logic [TAB_W-1:0]           rd_data;
    logic signed [COEF_W-1:0]   tab_val;
    logic signed [DIFF_W-1:0]   tab_diff;
    logic signed [DIFF_W+FRAC_W:0] interp_prod;
    logic signed [COEF_W-1:0]   interp;
    logic signed [COEF_W-1:0]   mag;
    logic signed [COEF_W-1:0]   coef_val;

    // quadrant fold, table index and interpolation fraction of one angle
    function automatic look_t decode(input logic [ANGLE_BITS-1:0] a);
        logic [1:0]            q;
        logic [U_W-1:0]        r;
        logic [U_W-1:0]        u;
        logic [U_W+SH_L-1:0]   uw;
        look_t                 lk;
        q       = a[ANGLE_BITS-1 -: 2];
        r       = U_W'(a[ANGLE_BITS-3:0]);
        u       = q[0] ? QUARTER_U - r : r;
        uw      = (U_W + SH_L)'(u);
        lk.addr = TAB_BITS'((uw >> SH_R) << SH_L);
        lk.frac = (SH_R > 0) ? FRAC_W'(u) : '0;
        lk.full = u[U_W-1];
        lk.neg  = q[1];
        return lk;
    endfunction

    assign look_s = decode(angle_reg);
    assign look_c = decode(angle_reg + QUARTER_A);
    assign raddr  = (state_reg == ST_SIN) ? look_s.addr : look_c.addr;

    pfr_ram
    #(
        .WIDTH (TAB_W),
        .DEPTH (TAB_SIZE)
    )
    u_tab
    (
        .clk   (clk),
        .we    (state_reg == ST_FILL),
        .waddr (fill_reg),
        .wdata (SINE_ROM[fill_reg]),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // table entry plus floored linear step, then quadrant sign
    always_comb
    begin
        info        = (state_reg == ST_FIN) ? look_c : look_s;
        tab_val     = $signed(COEF_W'(rd_data[TAB_W-1:DIFF_W]));
        tab_diff    = $signed(rd_data[DIFF_W-1:0]);
        interp_prod = tab_diff * $signed({1'b0, info.frac});
        interp      = COEF_W'(interp_prod >>> SH_R);
        mag         = info.full ? ONE_Q30 : tab_val + interp;
        coef_val    = info.neg ? -mag : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
            angle_reg <= '0;
            sin_reg   <= '0;
            cos_reg   <= ONE_Q30;
        end
        else
        begin
            case (state_reg)
                ST_FILL:
                begin
                    fill_reg <= fill_reg + 1'b1;
                    if (fill_reg == TAB_BITS'(TAB_SIZE - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        angle_reg <= angle;
                        state_reg <= ST_SIN;
                    end
                end
                ST_SIN:
                begin
                    state_reg <= ST_COS;
                end
                ST_COS:
                begin
                    sin_reg   <= coef_val;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    cos_reg   <= coef_val;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign trig.sin_v = sin_reg;
    assign trig.cos_v = cos_reg;

endmodule

[rtl/planar_frame_rotator_unit.sv]
// planar frame rotator: stored heading, 2x2 rotation of velocity vectors
// rotate items: accepted one per cycle unless busy or stalled; result passes the product, sum and output registers
// set heading: accepted, then busy through sine read, cosine read with sine update, then the cosine update
// reset: table copied into ram in the fill state with no item accepted, heading zero
// the table ram's single read port sets the set-heading cost; four multiplier pairs set rate
`timescale 1ns / 1ps

module planar_frame_rotator_unit
    import pfr_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DFLT,
    parameter int DATA_BITS  = DATA_BITS_DFLT
)
(
    input  logic       clk,
    input  logic       rst_n,
    pfr_in_if.sink     req,
    pfr_out_if.source  rsp
);

    // split of each vector component into a signed high and unsigned low half
    localparam int LO_W       = DATA_BITS / 2;
    localparam int HI_W       = DATA_BITS - LO_W;
    localparam int PH_W       = COEF_W + HI_W;
    localparam int PL_W       = COEF_W + LO_W + 1;
    localparam int SUM_W      = COEF_W + DATA_BITS + 2;
    localparam int RES_W      = SUM_W - COEF_FRAC;
    localparam int HEAD_EXT_W = (ANGLE_BITS > HEAD_W) ? ANGLE_BITS : HEAD_W;

    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (COEF_FRAC - 1);
    localparam logic [DATA_BITS-1:0] SAT_MAX = {1'b0, {(DATA_BITS - 1){1'b1}}};
    localparam logic [DATA_BITS-1:0] SAT_MIN = {1'b1, {(DATA_BITS - 1){1'b0}}};

    // handshake and control
    logic                    busy;
    logic                    accept;
    logic                    rot_acc;
    logic                    set_acc;
    logic                    o_free;
    logic                    s2_free;
    logic                    s2_adv;
    logic                    s1_free;
    logic                    s1_adv;
    logic                    s1_v_reg;
    logic                    s2_v_reg;
    logic                    o_v_reg;

    // heading and coefficients
    logic [HEAD_EXT_W-1:0]   head_ext;
    logic [ANGLE_BITS-1:0]   angle;
    pfr_trig_t               trig;
    logic signed [COEF_W-1:0] sin_c;
    logic signed [COEF_W-1:0] cos_c;

    // operand halves
    logic signed [HI_W-1:0]  xh;
    logic signed [HI_W-1:0]  yh;
    logic signed [LO_W:0]    xl;
    logic signed [LO_W:0]    yl;

    // partial products
    logic signed [PH_W-1:0]  m_cxh, m_syh, m_sxh, m_cyh;
    logic signed [PL_W-1:0]  m_cxl, m_syl, m_sxl, m_cyl;
    logic signed [PH_W-1:0]  p_cxh_reg, p_syh_reg, p_sxh_reg, p_cyh_reg;
    logic signed [PL_W-1:0]  p_cxl_reg, p_syl_reg, p_sxl_reg, p_cyl_reg;
    logic                    inv_reg;

    // sums
    logic signed [PH_W:0]    hx;
    logic signed [PH_W:0]    hy;
    logic signed [PL_W:0]    lx;
    logic signed [PL_W:0]    ly;
    logic signed [SUM_W-1:0] tot_x;
    logic signed [SUM_W-1:0] tot_y;
    logic signed [RES_W-1:0] rx_reg;
    logic signed [RES_W-1:0] ry_reg;
    logic [DATA_BITS-1:0]    out_x_reg;
    logic [DATA_BITS-1:0]    out_y_reg;

    // clamp a rounded sum to the signed data range
    function automatic logic [DATA_BITS-1:0] sat(input logic signed [RES_W-1:0] v);
        logic [RES_W-DATA_BITS:0] top;
        top = v[RES_W-1:DATA_BITS-1];
        if ((&top) || !(|top))
            return v[DATA_BITS-1:0];
        else
            return v[RES_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

    // backward flow: a stage takes a new item when empty or when it moves on
    assign o_free  = !o_v_reg || rsp.ready;
    assign s2_adv  = s2_v_reg && o_free;
    assign s2_free = !s2_v_reg || o_free;
    assign s1_adv  = s1_v_reg && s2_free;
    assign s1_free = !s1_v_reg || s2_free;

    assign req.ready = !busy && s1_free;
    assign accept    = req.valid && req.ready;
    assign rot_acc   = accept && (req.cmd inside {CMD_ROT_FWD, CMD_ROT_INV});
    assign set_acc   = accept && (req.cmd == CMD_SET_HEADING);

    // only the low angle bits of the heading field are kept
    assign head_ext = HEAD_EXT_W'(req.heading);
    assign angle    = head_ext[ANGLE_BITS-1:0];

    pfr_sincos
    #(
        .ANGLE_BITS (ANGLE_BITS)
    )
    u_sincos
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (set_acc),
        .angle (angle),
        .busy  (busy),
        .trig  (trig)
    );

    assign sin_c = $signed(trig.sin_v);
    assign cos_c = $signed(trig.cos_v);

    // stage one: eight partial products straight off the input item
    assign xh = $signed(req.vel_x[DATA_BITS-1:LO_W]);
    assign yh = $signed(req.vel_y[DATA_BITS-1:LO_W]);
    assign xl = $signed({1'b0, req.vel_x[LO_W-1:0]});
    assign yl = $signed({1'b0, req.vel_y[LO_W-1:0]});

    assign m_cxh = cos_c * xh;
    assign m_syh = sin_c * yh;
    assign m_sxh = sin_c * xh;
    assign m_cyh = cos_c * yh;
    assign m_cxl = cos_c * xl;
    assign m_syl = sin_c * yl;
    assign m_sxl = sin_c * xl;
    assign m_cyl = cos_c * yl;

    // stage two: forward turn x = cx - sy, y = sx + cy; inverse turn flips the s terms
    always_comb
    begin
        hx = inv_reg ? p_cxh_reg + p_syh_reg : p_cxh_reg - p_syh_reg;
        lx = inv_reg ? p_cxl_reg + p_syl_reg : p_cxl_reg - p_syl_reg;
        hy = inv_reg ? p_cyh_reg - p_sxh_reg : p_cyh_reg + p_sxh_reg;
        ly = inv_reg ? p_cyl_reg - p_sxl_reg : p_cyl_reg + p_sxl_reg;
        // recombine halves, round half up, drop the Q30 fraction
        tot_x = (SUM_W'(hx) <<< LO_W) + SUM_W'(lx) + HALF_LSB;
        tot_y = (SUM_W'(hy) <<< LO_W) + SUM_W'(ly) + HALF_LSB;
    end

    // valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (rot_acc)
                s1_v_reg <= 1'b1;
            else if (s1_adv)
                s1_v_reg <= 1'b0;

            if (s1_adv)
                s2_v_reg <= 1'b1;
            else if (s2_adv)
                s2_v_reg <= 1'b0;

            if (s2_adv)
                o_v_reg <= 1'b1;
            else if (rsp.ready)
                o_v_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rot_acc)
        begin
            p_cxh_reg <= m_cxh;
            p_syh_reg <= m_syh;
            p_sxh_reg <= m_sxh;
            p_cyh_reg <= m_cyh;
            p_cxl_reg <= m_cxl;
            p_syl_reg <= m_syl;
            p_sxl_reg <= m_sxl;
            p_cyl_reg <= m_cyl;
            inv_reg   <= (req.cmd == CMD_ROT_INV);
        end
        if (s1_adv)
        begin
            rx_reg <= RES_W'(tot_x >>> COEF_FRAC);
            ry_reg <= RES_W'(tot_y >>> COEF_FRAC);
        end
        if (s2_adv)
        begin
            out_x_reg <= sat(rx_reg);
            out_y_reg <= sat(ry_reg);
        end
    end

    assign rsp.valid = o_v_reg;
    assign rsp.out_x = $signed(out_x_reg);
    assign rsp.out_y = $signed(out_y_reg);

    // a result only appears after the sum stage held an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_v_reg) |-> $past(s2_v_reg))
        else $error("result appeared without a rounded sum behind it");

    // a new heading locks the input until its coefficients are in place
    assert property (@(posedge clk) disable iff (!rst_n)
        set_acc |=> busy)
        else $error("set heading did not start the coefficient update");

    // a full, stalled pipeline takes no further item
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && s2_v_reg && o_v_reg && !rsp.ready) |-> !req.ready)
        else $error("item taken while every stage was held");

endmodule
